// ----- rtl/pal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list: action and
// status codes, the command broadcast to the cell chain and the controller
// states.
// ----------------------------------------------------------------------------
package pal_pkg;

  // default sizes
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  // port field widths
  localparam int ACT_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // widest cell index (capacity up to 1024)
  localparam int MAX_IDX_W = 10;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR     = 3'd0,
    ACT_READ      = 3'd1,
    ACT_LOCATE    = 3'd2,
    ACT_INSERT    = 3'd3,
    ACT_DELETE    = 3'd4,
    ACT_OVERWRITE = 3'd5
  } action_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // operation applied by every cell in the same cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE,
    CELL_ROTATE
  } cell_op_t;

  // command broadcast along the chain
  typedef struct packed {
    cell_op_t               op;
    logic [MAX_IDX_W-1:0]   idx;
  } cell_cmd_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ----- rtl/pal_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell
// One list slot. Holds a single element and, on the broadcast command,
// keeps it, loads the new value, or takes the word of its left or right
// neighbor.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // select the next word for this slot
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX == cmd.idx) begin
          data_nxt = load_data;
        end else if (MY_IDX > cmd.idx) begin
          data_nxt = left_data;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      CELL_WRITE: begin
        if (MY_IDX == cmd.idx) begin
          data_nxt = load_data;
        end
      end
      CELL_ROTATE: begin
        data_nxt = right_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // element storage, no reset needed
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- rtl/positional_array_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of up to CAPACITY signed elements kept in a chain of cells,
// with clear, read, locate, insert, delete and overwrite by 1-based position.
// ----------------------------------------------------------------------------
// Usage
//   in_* carries one command word (action, position, value) with valid/ready.
//   out_* returns one result word per command: status, read value, found
//   position and the list length after the command.
//   Clear, insert, delete, overwrite and unknown codes finish in the accept
//   cycle: the result is valid on the next cycle and, when the output is
//   taken, a new command may follow right behind it.
//   Read and locate rotate the whole cell ring once past cell 0, one slot a
//   cycle, in the scan state, and load their result in the done state; the
//   ring is back in place when the result appears.
//   in_ready is high only when the controller is idle and the output
//   register is empty or being drained in the same cycle; a stalled
//   receiver therefore holds off new commands.
//   Reset (rst_n low, synchronous) empties the list and the output register;
//   cell contents are left as they are and are never read before written.
// ----------------------------------------------------------------------------
module positional_array_list import pal_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         in_action,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [VAL_W-1:0]  out_read_value,
  output logic [POS_W-1:0]         out_found_position,
  output logic [POS_W-1:0]         out_list_length
);

  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;
  localparam int EXT_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  // controller state
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      scan_r;
  action_t               act_r;
  logic [IDX_W-1:0]      pos_idx_r;
  logic                  pos_ok_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  hit_r;
  logic [CW-1:0]         found_r;
  logic [DATA_WIDTH-1:0] rd_r;

  // output register
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [VAL_W-1:0]      out_read_value_r;
  logic [POS_W-1:0]      out_found_r;
  logic [POS_W-1:0]      out_length_r;

  // handshake
  logic in_fire;
  logic out_free;
  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // decode of the incoming word
  action_t               in_act;
  logic [CW-1:0]         pos_ext;
  logic [CW-1:0]         cnt_ext;
  logic [CW-1:0]         pos_m1;
  logic                  pos_ok;
  logic                  ins_ok;
  logic                  is_full;
  logic [IDX_W-1:0]      pos_idx;
  logic signed [EXT_W-1:0] val_ext;
  logic [DATA_WIDTH-1:0] val_dw;

  assign in_act  = action_t'(in_action);
  assign pos_ext = CW'(in_position);
  assign cnt_ext = CW'(count_r);
  assign pos_m1  = pos_ext - CW'(1);
  assign pos_idx = pos_m1[IDX_W-1:0];
  assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + CW'(1));
  assign is_full = (count_r == FULL_CNT);
  assign val_ext = EXT_W'(in_value);
  assign val_dw  = val_ext[DATA_WIDTH-1:0];

  // cell chain
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] chain [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? CAPACITY - 1 : i - 1;
    localparam int RIGHT = (i == CAPACITY - 1) ? 0 : i + 1;
    pal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .load_data  (val_dw),
      .left_data  (chain[LEFT]),
      .right_data (chain[RIGHT]),
      .data       (chain[i])
    );
  end

  // scan compare at the head of the ring
  logic          scan_last;
  logic          read_hit;
  logic          loc_hit;
  logic [CW-1:0] scan_ext;
  assign scan_ext  = CW'(scan_r);
  assign scan_last = (scan_r == LAST_IDX);
  assign read_hit  = (act_r == ACT_READ) && (scan_r == pos_idx_r);
  assign loc_hit   = (act_r == ACT_LOCATE) && !hit_r && (scan_ext < cnt_ext)
                     && (chain[0] == val_r);

  // sign extension of the word read
  logic signed [EXT_W-1:0] rd_ext;
  assign rd_ext = EXT_W'(signed'(rd_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_act == ACT_READ || in_act == ACT_LOCATE)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // controller outputs
  logic              scan_start;
  logic              out_load;
  status_t           res_status;
  logic [VAL_W-1:0]  res_rd;
  logic [POS_W-1:0]  res_found;
  logic [CW-1:0]     len_ext;

  always_comb begin
    in_ready   = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    res_status = STAT_OK;
    res_rd     = '0;
    res_found  = '0;
    count_nxt  = count_r;
    cmd.op     = CELL_HOLD;
    cmd.idx    = MAX_IDX_W'(pos_idx);
    unique case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          out_load = 1'b1;
          case (in_act)
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_READ, ACT_LOCATE: begin
              out_load   = 1'b0;
              scan_start = 1'b1;
            end
            ACT_INSERT: begin
              if (!ins_ok) begin
                res_status = STAT_BAD_POS;
              end else if (is_full) begin
                res_status = STAT_FULL;
              end else begin
                cmd.op    = CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_DELETE: begin
              if (!pos_ok) begin
                res_status = STAT_BAD_POS;
              end else begin
                cmd.op    = CELL_DELETE;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ACT_OVERWRITE: begin
              if (!pos_ok) begin
                res_status = STAT_BAD_POS;
              end else begin
                cmd.op = CELL_WRITE;
              end
            end
            default: begin
              res_status = STAT_BAD_POS;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.op = CELL_ROTATE;
      end
      S_DONE: begin
        out_load = out_free;
        if (act_r == ACT_READ) begin
          res_status = pos_ok_r ? STAT_OK : STAT_BAD_POS;
          res_rd     = pos_ok_r ? rd_ext[VAL_W-1:0] : '0;
        end else begin
          res_status = hit_r ? STAT_OK : STAT_NOT_FOUND;
          res_found  = hit_r ? found_r[POS_W-1:0] : '0;
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  assign len_ext = CW'(count_nxt);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan registers and result word
  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_r    <= '0;
      hit_r     <= 1'b0;
      act_r     <= in_act;
      pos_idx_r <= pos_idx;
      pos_ok_r  <= pos_ok;
      val_r     <= val_dw;
    end else if (state_r == S_SCAN) begin
      scan_r <= scan_r + IDX_W'(1);
      if (read_hit) begin
        rd_r <= chain[0];
      end
      if (loc_hit) begin
        hit_r   <= 1'b1;
        found_r <= scan_ext + CW'(1);
      end
    end
    if (out_load) begin
      out_status_r     <= res_status;
      out_read_value_r <= res_rd;
      out_found_r      <= res_found;
      out_length_r     <= len_ext[POS_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = signed'(out_read_value_r);
  assign out_found_position = out_found_r;
  assign out_list_length    = out_length_r;

  // list never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("element count above capacity");

  // commands other than read and locate deliver a result word on the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_act != ACT_READ && in_act != ACT_LOCATE) |=> out_valid_r)
    else $error("missing result after single-cycle command");

  // length only moves when a command word is taken
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> count_r == $past(count_r))
    else $error("element count changed without a command");

endmodule

// ----- sim/positional_array_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_checker
// Watches the command and result channels of the positional array list,
// keeps its own copy of the list, predicts one result word per accepted
// command and compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module positional_array_list_checker import pal_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [ACT_W-1:0]         in_action,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STAT_W-1:0]        out_status,
  input  logic signed [VAL_W-1:0]  out_read_value,
  input  logic [POS_W-1:0]         out_found_position,
  input  logic [POS_W-1:0]         out_list_length,
  output int                       mismatches,
  output int                       pending,
  output logic [POS_W-1:0]         model_len
);

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  read_value;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  list_length;
  } list_result_t;

  // shadow list and the results still owed by the block
  logic [VAL_W-1:0] cells [CAPACITY];
  int               cell_count = 0;
  list_result_t     owed_q [$];
  int               err_count = 0;

  // apply one command word to the shadow list and return its result
  function automatic list_result_t apply_word(input logic [ACT_W-1:0] act,
                                              input logic [POS_W-1:0] pos,
                                              input logic [VAL_W-1:0] val);
    list_result_t r;
    int           p;
    r = '0;
    r.status = STAT_OK;
    p = int'(pos);
    case (act)
      ACT_CLEAR: begin
        cell_count = 0;
      end
      ACT_READ: begin
        if (p < 1 || p > cell_count) r.status = STAT_BAD_POS;
        else r.read_value = cells[p-1];
      end
      ACT_LOCATE: begin
        r.status = STAT_NOT_FOUND;
        for (int k = 0; k < cell_count && r.status == STAT_NOT_FOUND; k++) begin
          if (cells[k] == val) begin
            r.status         = STAT_OK;
            r.found_position = POS_W'(k + 1);
          end
        end
      end
      ACT_INSERT: begin
        if (p < 1 || p > cell_count + 1) r.status = STAT_BAD_POS;
        else if (cell_count >= CAPACITY) r.status = STAT_FULL;
        else begin
          for (int k = cell_count; k > p - 1; k--) cells[k] = cells[k-1];
          cells[p-1] = val;
          cell_count++;
        end
      end
      ACT_DELETE: begin
        if (p < 1 || p > cell_count) r.status = STAT_BAD_POS;
        else begin
          for (int k = p - 1; k + 1 < cell_count; k++) cells[k] = cells[k+1];
          cell_count--;
        end
      end
      ACT_OVERWRITE: begin
        if (p < 1 || p > cell_count) r.status = STAT_BAD_POS;
        else cells[p-1] = val;
      end
      // unused codes leave the list alone
      default: r.status = STAT_BAD_POS;
    endcase
    r.list_length = POS_W'(cell_count);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                      input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // results first: an accepted result always belongs to an older command
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      cell_count = 0;
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t ns: result word with no command pending, status %0h",
                   $time, out_status);
          err_count++;
        end else begin
          want = owed_q.pop_front();
          check_field("status", VAL_W'(want.status), VAL_W'(out_status));
          check_field("read_value", want.read_value, out_read_value);
          check_field("found_position", VAL_W'(want.found_position),
                      VAL_W'(out_found_position));
          check_field("list_length", VAL_W'(want.list_length), VAL_W'(out_list_length));
        end
      end
      if (in_valid && in_ready)
        owed_q.push_back(apply_word(in_action, in_position, in_value));
    end
    mismatches <= err_count;
    pending    <= owed_q.size();
    model_len  <= POS_W'(cell_count);
  end

endmodule

// ----- sim/positional_array_list_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_tb
// Drives command words into the positional array list: a directed run over
// empty-list errors, front/middle/end insert, front/end delete, extreme values and
// unused codes, then random segments that fill, churn and drain the list
// under changing idle and stall patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module positional_array_list_tb import pal_pkg::*; ();

  localparam int CLK_PERIOD   = 4;
  localparam int NUM_SEGMENTS = 10;
  localparam int SEG_WORDS    = 110;
  localparam int PRESSURE_SEG = 5;
  localparam int HOLD_CYCLES  = 300;
  localparam int RUN_LIMIT_NS = 2_000_000;

  // codes the block does not define
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [ACT_W-1:0]         in_action = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [VAL_W-1:0]  in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [VAL_W-1:0]  out_read_value;
  logic [POS_W-1:0]         out_found_position;
  logic [POS_W-1:0]         out_list_length;

  int                       mismatches;
  int                       pending;
  logic [POS_W-1:0]         model_len;

  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;
  logic                     pressure_on = 1'b0;
  int                       hold_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  positional_array_list u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  positional_array_list_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length),
    .mismatches         (mismatches),
    .pending            (pending),
    .model_len          (model_len)
  );

  // receiver: one long hold-off when pressure is asked, random stalls otherwise
  always @(posedge clk) begin
    if (pressure_on && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it, and wait for accept
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    mix_t              mix;
    int                w_ins;
    int                w_del;
    int                roll;
    int                hi;
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every positional action is out of range
    send_word(ACT_CLEAR, 0, 0);
    send_word(ACT_READ, 1, 0);
    send_word(ACT_DELETE, 1, 0);
    send_word(ACT_OVERWRITE, 1, 32'h1234_5678);
    send_word(ACT_LOCATE, 0, 0);
    send_word(ACT_INSERT, 2, 32'h5);
    send_word(ACT_INSERT, 0, 32'h5);
    // build [-1, 0, max, min] through first, end, front and middle inserts
    send_word(ACT_INSERT, 1, 32'h7FFF_FFFF);
    send_word(ACT_INSERT, 2, 32'h8000_0000);
    send_word(ACT_INSERT, 1, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 2, 32'h0);
    send_word(ACT_READ, 1, 0);
    send_word(ACT_READ, 4, 0);
    send_word(ACT_READ, 5, 0);
    send_word(ACT_READ, 127, 0);
    send_word(ACT_LOCATE, 127, 32'h8000_0000);
    send_word(ACT_LOCATE, 0, 32'd12345);
    // duplicate value: locate reports the first hit
    send_word(ACT_OVERWRITE, 2, 32'h8000_0000);
    send_word(ACT_LOCATE, 0, 32'h8000_0000);
    send_word(ACT_OVERWRITE, 0, 32'h1);
    send_word(ACT_DELETE, 1, 0);
    send_word(ACT_DELETE, 3, 0);
    send_word(ACT_READ, 1, 0);
    send_word(ACT_UNUSED_LO, 1, 0);
    send_word(ACT_UNUSED_HI, 127, 32'hFFFF_FFFF);
    // clear keeps old cells but nothing is readable
    send_word(ACT_CLEAR, 127, 32'hFFFF_FFFF);
    send_word(ACT_READ, 1, 0);

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      // idle pattern per segment
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 82; end
        default: begin send_idle_pct = 27; recv_stall_pct <= 27; end
      endcase
      pressure_on <= (seg == PRESSURE_SEG);
      mix = mix_t'(seg % 3);
      case (mix)
        MIX_FILL:  begin w_ins = 75; w_del = 3;  end
        MIX_DRAIN: begin w_ins = 15; w_del = 55; end
        default:   begin w_ins = 30; w_del = 27; end
      endcase

      for (int n = 0; n < SEG_WORDS; n++) begin
        // action mix follows the segment's fill/drain bias
        roll = $urandom_range(99);
        if (roll < w_ins) act = ACT_INSERT;
        else if (roll < w_ins + w_del) act = ACT_DELETE;
        else begin
          roll = $urandom_range(19);
          if (roll < 7) act = ACT_READ;
          else if (roll < 14) act = ACT_LOCATE;
          else if (roll < 18) act = ACT_OVERWRITE;
          else if (roll == 18 && mix != MIX_FILL) act = ACT_CLEAR;
          else if (roll == 18) act = ACT_OVERWRITE;
          else act = ACT_UNUSED_LO | ACT_W'($urandom_range(1));
        end

        // mostly in-range positions, the rest zero or past the end
        hi = (act == ACT_INSERT) ? int'(model_len) + 1 : int'(model_len);
        if ($urandom_range(99) < 88 && hi != 0) pos = POS_W'($urandom_range(hi, 1));
        else if ($urandom_range(3) == 0) pos = '0;
        else pos = POS_W'($urandom_range(127, (hi + 1 > 127) ? 127 : hi + 1));

        // small value pool so locate and duplicates hit often
        roll = $urandom_range(9);
        if (roll < 4) val = VAL_W'($urandom_range(7));
        else if (roll == 4) begin
          case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'hFFFF_FFFF;
            default: val = 32'h0;
          endcase
        end else val = $urandom;

        send_word(act, pos, val);
      end
    end

    // drain everything still owed, then let the ring settle
    in_valid       <= 1'b0;
    pressure_on    <= 1'b0;
    recv_stall_pct <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DEF_CAPACITY + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
